@@ hdl/roi_ae_pkg.sv @@
// Shared types and constants for the ROI auto-exposure block.
// Pixel and result item structs, register map, adjustment codes.
// No dependencies.
package roi_ae_pkg;

  localparam int COORD_BITS = 12;
  localparam int CNT_BITS   = 2 * COORD_BITS + 1;
  localparam int SUM_BITS   = 2 * COORD_BITS + 10;
  localparam int EXPO_W     = 14;
  localparam int ADDR_W     = 5;
  localparam int REG_IDX_W  = 3;

  localparam int EXPO_MIN     = 1;
  localparam int EXPO_MAX     = 10000;
  localparam int EXPO_RESET   = 1000;
  localparam int LIGHT_LIMIT  = 250;
  localparam int FAST_STEP    = 200;
  localparam int SLOW_STEP    = 50;
  localparam int BEACON_DROP  = 5;
  localparam int SCALE_NORM   = 3;
  localparam int SCALE_BEACON = 10;

  localparam logic [7:0] TARGET_RESET    = 8'd128;
  localparam logic [7:0] TOLERANCE_RESET = 8'd10;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_TARGET_GRAY = 3'd0,
    REG_TOLERANCE   = 3'd1,
    REG_BEACON_MODE = 3'd2,
    REG_CENTER_X    = 3'd3,
    REG_CENTER_Y    = 3'd4,
    REG_WIDTH       = 3'd5,
    REG_HEIGHT      = 3'd6,
    REG_INIT_EXPO   = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    ADJ_NONE     = 2'd0,
    ADJ_FAST_DEC = 2'd1,
    ADJ_DEC      = 2'd2,
    ADJ_INC      = 2'd3
  } adj_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] pix_x;
    logic [COORD_BITS-1:0] pix_y;
    logic [7:0]            blue;
    logic [7:0]            green;
    logic [7:0]            red;
    logic                  last_pixel;
  } pix_t;

  typedef struct packed {
    logic [EXPO_W-1:0]   exposure_time;
    adj_t                adjustment;
    logic [SUM_BITS-1:0] lit_sum;
    logic [CNT_BITS-1:0] counted_pixels;
  } res_t;

  typedef struct packed {
    logic [7:0]        target_gray;
    logic [7:0]        tolerance;
    logic              beacon_mode;
    logic [15:0]       box_center_x;
    logic [15:0]       box_center_y;
    logic [15:0]       box_width;
    logic [15:0]       box_height;
    logic [EXPO_W-1:0] initial_exposure;
  } cfg_t;

  // Frame totals handed from the accumulator to the decision stage
  typedef struct packed {
    logic [SUM_BITS-1:0] sum;
    logic [CNT_BITS-1:0] cnt;
  } frm_t;

endpackage

@@ hdl/roi_auto_exposure_step_top.sv @@
// ROI auto exposure: one pixel item per clock while in_stall is low, one result item per frame.
// Path: after its last pixel is accepted, a result passes through the input register,
// frame capture, threshold products and result register.
// Throughput: 1 pixel per cycle while in_stall is low; in_stall rises only when a last
// pixel meets frame results held in frame slot, decision stage and stalled output.
// Reset (rst_n, synchronous): registers at defaults, accumulators zero, exposure 1000.
module roi_auto_exposure_step_top import roi_ae_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  // pixel input
  input  logic              in_valid,
  output logic              in_stall,
  input  pix_t              in_data,
  // frame result
  output logic              out_valid,
  input  logic              out_stall,
  output res_t              out_data,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t cfg;
  logic expo_load;
  logic frm_vld, frm_take;
  frm_t frm;

  // Register file; a write to the initial exposure reloads the exposure state
  roi_ae_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .cfg       (cfg),
    .expo_load (expo_load)
  );

  // Per-pixel region test and saturating count/sum; frame totals on last pixel
  roi_ae_acc u_acc (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .frm_vld  (frm_vld),
    .frm      (frm),
    .frm_take (frm_take)
  );

  // Per-frame decision: products, compare, exposure step, result item
  roi_ae_dec u_dec (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .expo_load (expo_load),
    .frm_vld   (frm_vld),
    .frm       (frm),
    .frm_take  (frm_take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

@@ hdl/roi_ae_cfg.sv @@
// Configuration register file on an APB-style port.
// Depends on roi_ae_pkg.
module roi_ae_cfg import roi_ae_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg,
  output logic              expo_load
);

  cfg_t     cfg_r, cfg_nxt;
  logic     expo_load_r, expo_load_nxt;
  logic     wr;
  reg_idx_t idx;

  assign wr     = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign pready = 1'b1;

  always_comb begin
    cfg_nxt       = cfg_r;
    expo_load_nxt = 1'b0;
    if (wr) begin
      unique case (idx)
        REG_TARGET_GRAY: cfg_nxt.target_gray  = pwdata[7:0];
        REG_TOLERANCE:   cfg_nxt.tolerance    = pwdata[7:0];
        REG_BEACON_MODE: cfg_nxt.beacon_mode  = pwdata[0];
        REG_CENTER_X:    cfg_nxt.box_center_x = pwdata[15:0];
        REG_CENTER_Y:    cfg_nxt.box_center_y = pwdata[15:0];
        REG_WIDTH:       cfg_nxt.box_width    = pwdata[15:0];
        REG_HEIGHT:      cfg_nxt.box_height   = pwdata[15:0];
        REG_INIT_EXPO: begin
          cfg_nxt.initial_exposure = pwdata[EXPO_W-1:0];
          expo_load_nxt            = 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_TARGET_GRAY: prdata = {24'd0, cfg_r.target_gray};
      REG_TOLERANCE:   prdata = {24'd0, cfg_r.tolerance};
      REG_BEACON_MODE: prdata = {31'd0, cfg_r.beacon_mode};
      REG_CENTER_X:    prdata = {16'd0, cfg_r.box_center_x};
      REG_CENTER_Y:    prdata = {16'd0, cfg_r.box_center_y};
      REG_WIDTH:       prdata = {16'd0, cfg_r.box_width};
      REG_HEIGHT:      prdata = {16'd0, cfg_r.box_height};
      REG_INIT_EXPO:   prdata = {{(32-EXPO_W){1'b0}}, cfg_r.initial_exposure};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_gray      <= TARGET_RESET;
      cfg_r.tolerance        <= TOLERANCE_RESET;
      cfg_r.beacon_mode      <= 1'b0;
      cfg_r.box_center_x     <= '0;
      cfg_r.box_center_y     <= '0;
      cfg_r.box_width        <= '0;
      cfg_r.box_height       <= '0;
      cfg_r.initial_exposure <= EXPO_W'(EXPO_RESET);
      expo_load_r            <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      expo_load_r <= expo_load_nxt;
    end
  end

  // Load strobe is registered along with cfg_r, so the new value is already in cfg_r
  assign cfg       = cfg_r;
  assign expo_load = expo_load_r;

endmodule

@@ hdl/roi_ae_acc.sv @@
// Input register, region test and per-frame brightness accumulation.
// Depends on roi_ae_pkg.
module roi_ae_acc import roi_ae_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  cfg_t cfg,
  input  logic in_valid,
  output logic in_stall,
  input  pix_t in_data,
  output logic frm_vld,
  output frm_t frm,
  input  logic frm_take
);

  localparam int SW1 = SUM_BITS + 1;
  localparam logic [CNT_BITS-1:0] CNT_MAX = '1;
  localparam logic [SUM_BITS-1:0] SUM_MAX = '1;

  pix_t                pix_r, pix_nxt;
  logic                pix_vld_r, pix_vld_nxt;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt, cnt_upd;
  logic [SUM_BITS-1:0] sum_r, sum_nxt, sum_upd;
  logic [SW1-1:0]      sum_wide;
  frm_t                frm_r, frm_nxt;
  logic                frm_vld_r, frm_vld_nxt;
  logic                has_target, in_box, lit, frm_free, pix_move, accept;

  // Half-open interval test on one axis, bounds in whole pixels
  function automatic logic axis_in(logic [COORD_BITS-1:0] p, logic [15:0] c,
                                   logic [15:0] sz, logic beacon);
    logic [19:0] span;
    logic [20:0] hi_sum, lo_diff;
    logic [16:0] lo, hi;
    span    = beacon ? 20'(sz) * 20'(SCALE_BEACON) : 20'(sz) * 20'(SCALE_NORM);
    hi_sum  = 21'(c) + 21'(span);
    lo_diff = 21'(c) - 21'(span);
    hi      = hi_sum[20:4];
    lo      = (21'(c) > 21'(span)) ? lo_diff[20:4] : 17'd0;
    return (17'(p) >= lo) && (17'(p) < hi);
  endfunction

  assign has_target = (|cfg.box_width) && (|cfg.box_height) && (|cfg.box_center_x);
  assign in_box     = !has_target ||
                      (axis_in(pix_r.pix_x, cfg.box_center_x, cfg.box_width,
                               cfg.beacon_mode) &&
                       axis_in(pix_r.pix_y, cfg.box_center_y, cfg.box_height,
                               cfg.beacon_mode));
  assign lit = (pix_r.blue  < 8'(LIGHT_LIMIT)) &&
               (pix_r.green < 8'(LIGHT_LIMIT)) &&
               (pix_r.red   < 8'(LIGHT_LIMIT));

  assign sum_wide = SW1'(sum_r) + SW1'(pix_r.blue) + SW1'(pix_r.green) + SW1'(pix_r.red);

  always_comb begin
    cnt_upd = cnt_r;
    sum_upd = sum_r;
    if (in_box) begin
      if (cnt_r != CNT_MAX) cnt_upd = cnt_r + 1'b1;
      if (lit) sum_upd = sum_wide[SUM_BITS] ? SUM_MAX : sum_wide[SUM_BITS-1:0];
    end
  end

  // A last pixel can only retire when the frame slot is free
  assign frm_free = !frm_vld_r || frm_take;
  assign pix_move = pix_vld_r && (!pix_r.last_pixel || frm_free);
  assign in_stall = pix_vld_r && !pix_move;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    pix_nxt     = pix_r;
    pix_vld_nxt = pix_vld_r;
    cnt_nxt     = cnt_r;
    sum_nxt     = sum_r;
    frm_nxt     = frm_r;
    frm_vld_nxt = frm_vld_r;
    if (frm_take) frm_vld_nxt = 1'b0;
    if (pix_move) begin
      pix_vld_nxt = 1'b0;
      if (pix_r.last_pixel) begin
        frm_nxt.sum = sum_upd;
        frm_nxt.cnt = cnt_upd;
        frm_vld_nxt = 1'b1;
        cnt_nxt     = '0;
        sum_nxt     = '0;
      end else begin
        cnt_nxt = cnt_upd;
        sum_nxt = sum_upd;
      end
    end
    if (accept) begin
      pix_nxt     = in_data;
      pix_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_vld_r <= 1'b0;
      frm_vld_r <= 1'b0;
      cnt_r     <= '0;
      sum_r     <= '0;
    end else begin
      pix_vld_r <= pix_vld_nxt;
      frm_vld_r <= frm_vld_nxt;
      cnt_r     <= cnt_nxt;
      sum_r     <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pix_r <= pix_nxt;
    frm_r <= frm_nxt;
  end

  assign frm_vld = frm_vld_r;
  assign frm     = frm_r;

endmodule

@@ hdl/roi_ae_dec.sv @@
// Exposure decision: threshold products, compare, exposure step, result register.
// Depends on roi_ae_pkg.
module roi_ae_dec import roi_ae_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  cfg_t cfg,
  input  logic expo_load,
  input  logic frm_vld,
  input  frm_t frm,
  output logic frm_take,
  output logic out_valid,
  input  logic out_stall,
  output res_t out_data
);

  localparam int KW = 14;
  localparam int PW = CNT_BITS + 1 + KW;
  localparam int EW = EXPO_W + 2;

  logic signed [9:0]       te;
  logic signed [KW-1:0]    te_k, tol_k, hi_k, lo_k, k1, k2, k3;
  logic signed [CNT_BITS:0] n_s;
  logic signed [PW-1:0]    p1_r, p2_r, p3_r, p1_nxt, p2_nxt, p3_nxt, s_s, s2;
  logic [SUM_BITS-1:0]     sum_r;
  logic [CNT_BITS-1:0]     cnt_r;
  logic                    d2_vld_r, d2_vld_nxt, d2_free, out_ld;
  logic                    out_vld_r, out_vld_nxt;
  res_t                    out_r, out_nxt;
  adj_t                    adj;
  logic signed [EW-1:0]    ex_s, delta, ex_new;
  logic [EXPO_W-1:0]       expo_r, expo_nxt, ex_clamp, init_clamp;

  // Thresholds scaled so the mean S/(3N) is compared by cross-multiplying
  assign te    = signed'({2'b00, cfg.target_gray}) -
                 (cfg.beacon_mode ? 10'sd5 : 10'sd0);
  assign te_k  = KW'(te);
  assign tol_k = signed'(KW'(cfg.tolerance));
  assign hi_k  = te_k + tol_k;
  assign lo_k  = te_k - tol_k;
  assign k1    = (te_k <<< 4) - te_k;
  assign k2    = (hi_k <<< 1) + hi_k;
  assign k3    = (lo_k <<< 1) + lo_k;
  assign n_s   = signed'({1'b0, frm.cnt});

  assign p1_nxt = k1 * n_s;
  assign p2_nxt = k2 * n_s;
  assign p3_nxt = k3 * n_s;

  assign out_ld   = d2_vld_r && (!out_vld_r || !out_stall);
  assign d2_free  = !d2_vld_r || out_ld;
  assign frm_take = frm_vld && d2_free;

  assign s_s = signed'(PW'(sum_r));
  assign s2  = s_s <<< 1;

  always_comb begin
    priority if (cnt_r == '0)  adj = ADJ_NONE;
    else if (s2 > p1_r)        adj = ADJ_FAST_DEC;
    else if (s_s > p2_r)       adj = ADJ_DEC;
    else if (s_s < p3_r)       adj = ADJ_INC;
    else                       adj = ADJ_NONE;
  end

  always_comb begin
    unique case (adj)
      ADJ_FAST_DEC: delta = -EW'(FAST_STEP);
      ADJ_DEC:      delta = -EW'(SLOW_STEP);
      ADJ_INC:      delta = EW'(SLOW_STEP);
      ADJ_NONE:     delta = '0;
    endcase
  end

  assign ex_s   = signed'(EW'(expo_r));
  assign ex_new = ex_s + delta;

  always_comb begin
    priority if (ex_new < EW'(EXPO_MIN)) ex_clamp = EXPO_W'(EXPO_MIN);
    else if (ex_new > EW'(EXPO_MAX))     ex_clamp = EXPO_W'(EXPO_MAX);
    else                                 ex_clamp = ex_new[EXPO_W-1:0];
  end

  always_comb begin
    priority if (cfg.initial_exposure == '0)      init_clamp = EXPO_W'(EXPO_MIN);
    else if (cfg.initial_exposure > EXPO_W'(EXPO_MAX)) init_clamp = EXPO_W'(EXPO_MAX);
    else                                          init_clamp = cfg.initial_exposure;
  end

  always_comb begin
    expo_nxt    = expo_r;
    out_nxt     = out_r;
    out_vld_nxt = out_vld_r;
    d2_vld_nxt  = d2_vld_r;
    if (!out_stall) out_vld_nxt = 1'b0;
    if (out_ld) begin
      d2_vld_nxt             = 1'b0;
      out_vld_nxt            = 1'b1;
      expo_nxt               = ex_clamp;
      out_nxt.exposure_time  = ex_clamp;
      out_nxt.adjustment     = adj;
      out_nxt.lit_sum        = sum_r;
      out_nxt.counted_pixels = cnt_r;
    end
    if (frm_take) d2_vld_nxt = 1'b1;
    if (expo_load) expo_nxt = init_clamp;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d2_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      expo_r    <= EXPO_W'(EXPO_RESET);
    end else begin
      d2_vld_r  <= d2_vld_nxt;
      out_vld_r <= out_vld_nxt;
      expo_r    <= expo_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (frm_take) begin
      p1_r  <= p1_nxt;
      p2_r  <= p2_nxt;
      p3_r  <= p3_nxt;
      sum_r <= frm.sum;
      cnt_r <= frm.cnt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

@@ hdl/roi_ae_chk.sv @@
// Port-level checks for the ROI auto-exposure top level, with its bind.
// Depends on roi_ae_pkg.
module roi_ae_chk import roi_ae_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_stall,
  input res_t out_data
);

  localparam int BW = SUM_BITS + 11;

  // A stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  a_expo_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.exposure_time >= EXPO_W'(EXPO_MIN)) &&
                  (out_data.exposure_time <= EXPO_W'(EXPO_MAX)))
    else $error("exposure out of range");

  // Empty region leaves exposure alone
  a_empty_none: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.counted_pixels == '0) |-> out_data.adjustment == ADJ_NONE)
    else $error("adjustment on empty region");

  // Each counted pixel adds at most 3*249; the check uses the looser 3*255
  a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> BW'(out_data.lit_sum) <= BW'(out_data.counted_pixels) * BW'(765))
    else $error("sum exceeds count bound");

endmodule

bind roi_auto_exposure_step_top roi_ae_chk u_roi_ae_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
